/* rtl/wbit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbit_pkg
// Shared widths, constants, register indexes and the sequencer state type
// for the work/break interval timer.
// ----------------------------------------------------------------------------
package wbit_pkg;

  // Field widths
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned SessW    = 7;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  // Datapath widths for the percent computation
  localparam int unsigned TimeW = 12;  // up to 63*60+59 seconds
  localparam int unsigned NumW  = 19;  // elapsed seconds times 100
  localparam int unsigned DivW  = NumW - 1;
  localparam int unsigned CntW  = 3;   // one step per quotient bit

  // Timer constants
  localparam logic [SecW-1:0]  LastSecond = 6'd59;
  localparam logic [SecW-1:0]  WarnSecond = 6'd10;
  localparam logic [CntW-1:0]  DivSteps   = 3'd6;  // quotient bit index of the first step
  localparam logic [SessW-1:0] FirstSess  = 7'd1;

  // Register reset values
  localparam logic [MinW-1:0]  WorkMinRst  = 6'd25;
  localparam logic [MinW-1:0]  ShortMinRst = 6'd5;
  localparam logic [MinW-1:0]  LongMinRst  = 6'd15;
  localparam logic [SessW-1:0] SessTotRst  = 7'd4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WORK_MIN  = 3'd0,
    REG_SHORT_MIN = 3'd1,
    REG_LONG_MIN  = 3'd2,
    REG_SESS_TOT  = 3'd3
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } seq_state_e;

endpackage

/* rtl/work_break_interval_timer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_break_interval_timer_core
// Work/break countdown timer with a bit-serial percent-elapsed divider.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i/in_ready_o, restart_i): one transaction per
//   elapsed second (restart_i = 0) or a reload to work, session one (1).
// - Output channel (out_valid_o/out_ready_i): one result transaction per
//   input, showing the timer state after the update and the percent elapsed.
// - Config channel (cfg_valid_i/cfg_ready_o): always ready; a write to a
//   listed register also reloads the timer. Write only while idle.
// - Sequence after input acceptance: PREP forms phase length and time left
//   in seconds, MUL scales by 100, DIV runs seven restoring-division steps
//   (one quotient bit per cycle) and FIN loads the output register. One item
//   is in flight at a time; the input is ready again once FIN has loaded
//   the result.
// - A stalled receiver holds the finished result in the output register; the
//   next input is taken once the result is loaded there, and a further
//   result waits in the sequencer until the register is free.
// - Reset restores register defaults (25/5/15 minutes, 4 sessions) and loads
//   the work phase of session one at 25:00.
// ----------------------------------------------------------------------------
module work_break_interval_timer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wbit_pkg::MinW-1:0]       minutes_left_o,
  output logic [wbit_pkg::SecW-1:0]       seconds_left_o,
  output logic [wbit_pkg::SessW-1:0]      session_number_o,
  output logic                            in_work_o,
  output logic [wbit_pkg::PctW-1:0]       percent_elapsed_o,
  output logic                            phase_end_o,
  output logic                            warning_o,
  output logic                            all_done_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wbit_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wbit_pkg::CfgDataW-1:0]   cfg_data_i
);

  // Configuration registers
  logic [wbit_pkg::MinW-1:0]  work_min_q, work_min_d;
  logic [wbit_pkg::MinW-1:0]  short_min_q, short_min_d;
  logic [wbit_pkg::MinW-1:0]  long_min_q, long_min_d;
  logic [wbit_pkg::SessW-1:0] sess_tot_q, sess_tot_d;

  // Timer state
  logic [wbit_pkg::MinW-1:0]  min_q, min_d;
  logic [wbit_pkg::SecW-1:0]  sec_q, sec_d;
  logic [wbit_pkg::SessW-1:0] sess_q, sess_d;
  logic                       work_q, work_d;
  logic [wbit_pkg::MinW-1:0]  len_q, len_d;
  logic                       ended_q, ended_d;
  logic                       warn_q, warn_d;
  logic                       done_q, done_d;

  // Percent datapath
  logic [wbit_pkg::TimeW-1:0] total_q, left_q;
  logic [wbit_pkg::NumW-1:0]  rem_q;
  logic [wbit_pkg::DivW-1:0]  dvs_q;
  logic [wbit_pkg::PctW-1:0]  quo_q;
  logic [wbit_pkg::CntW-1:0]  cnt_q;
  logic                       pct_zero_q;
  logic [wbit_pkg::TimeW-1:0] total_c, left_c, diff_c;
  logic [wbit_pkg::NumW-1:0]  diff_ext, num_c, rem_sub;
  logic                       rem_ge;

  // Sequencer
  wbit_pkg::seq_state_e state_q, state_d;
  logic in_acc, cfg_acc, cfg_hit, out_free;
  logic prep_en, mul_en, div_en, fin_en;

  // Output register
  logic out_valid_q;
  logic [wbit_pkg::MinW-1:0]  out_min_q;
  logic [wbit_pkg::SecW-1:0]  out_sec_q;
  logic [wbit_pkg::SessW-1:0] out_sess_q;
  logic                       out_work_q;
  logic [wbit_pkg::PctW-1:0]  out_pct_q;
  logic                       out_end_q, out_warn_q, out_done_q;

  assign in_acc   = in_valid_i && in_ready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wbit_pkg::ST_IDLE: if (in_acc) state_d = wbit_pkg::ST_PREP;
      wbit_pkg::ST_PREP: state_d = wbit_pkg::ST_MUL;
      wbit_pkg::ST_MUL:  state_d = wbit_pkg::ST_DIV;
      wbit_pkg::ST_DIV:  if (cnt_q == '0) state_d = wbit_pkg::ST_FIN;
      wbit_pkg::ST_FIN:  if (out_free) state_d = wbit_pkg::ST_IDLE;
      default:           state_d = wbit_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    prep_en    = 1'b0;
    mul_en     = 1'b0;
    div_en     = 1'b0;
    fin_en     = 1'b0;
    unique case (state_q)
      wbit_pkg::ST_IDLE: in_ready_o = 1'b1;
      wbit_pkg::ST_PREP: prep_en    = 1'b1;
      wbit_pkg::ST_MUL:  mul_en     = 1'b1;
      wbit_pkg::ST_DIV:  div_en     = 1'b1;
      wbit_pkg::ST_FIN:  fin_en     = out_free;
      default:           in_ready_o = 1'b0;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // Register write decode
  always_comb begin
    work_min_d  = work_min_q;
    short_min_d = short_min_q;
    long_min_d  = long_min_q;
    sess_tot_d  = sess_tot_q;
    cfg_hit     = 1'b0;
    if (cfg_acc) begin
      unique case (wbit_pkg::cfg_reg_e'(cfg_index_i))
        wbit_pkg::REG_WORK_MIN: begin
          work_min_d = cfg_data_i[wbit_pkg::MinW-1:0];
          cfg_hit    = 1'b1;
        end
        wbit_pkg::REG_SHORT_MIN: begin
          short_min_d = cfg_data_i[wbit_pkg::MinW-1:0];
          cfg_hit     = 1'b1;
        end
        wbit_pkg::REG_LONG_MIN: begin
          long_min_d = cfg_data_i[wbit_pkg::MinW-1:0];
          cfg_hit    = 1'b1;
        end
        wbit_pkg::REG_SESS_TOT: begin
          sess_tot_d = cfg_data_i[wbit_pkg::SessW-1:0];
          cfg_hit    = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Timer update on each input transaction or listed register write
  always_comb begin
    min_d   = min_q;
    sec_d   = sec_q;
    sess_d  = sess_q;
    work_d  = work_q;
    len_d   = len_q;
    ended_d = ended_q;
    warn_d  = warn_q;
    done_d  = done_q;
    if (cfg_hit) begin
      min_d  = work_min_d;
      sec_d  = '0;
      sess_d = wbit_pkg::FirstSess;
      work_d = 1'b1;
      len_d  = work_min_d;
    end else if (in_acc) begin
      ended_d = 1'b0;
      warn_d  = 1'b0;
      done_d  = 1'b0;
      if (restart_i || (sec_q == '0 && min_q == '0 && sess_q >= sess_tot_q)) begin
        // reload to work, session one; at the end of the last phase flag it
        min_d   = work_min_q;
        sec_d   = '0;
        sess_d  = wbit_pkg::FirstSess;
        work_d  = 1'b1;
        len_d   = work_min_q;
        ended_d = !restart_i;
        done_d  = !restart_i;
      end else if (sec_q == '0 && min_q != '0) begin
        sec_d = wbit_pkg::LastSecond;
        min_d = min_q - 6'd1;
      end else if (sec_q == '0) begin
        // phase expired: switch between work and break
        ended_d = 1'b1;
        work_d  = !work_q;
        sec_d   = '0;
        if (!work_q) begin
          len_d  = work_min_q;
          min_d  = work_min_q;
          sess_d = sess_q + 7'd1;
        end else if (sess_q[1:0] == 2'b00) begin
          len_d = long_min_q;
          min_d = long_min_q;
        end else begin
          len_d = short_min_q;
          min_d = short_min_q;
        end
      end else begin
        warn_d = (sec_q == wbit_pkg::WarnSecond) && (min_q == '0);
        sec_d  = sec_q - 6'd1;
      end
    end
  end

  // Seconds forms: n*60 = n*64 - n*4
  assign total_c = ({6'd0, len_q} << 6) - ({6'd0, len_q} << 2);
  assign left_c  = ({6'd0, min_q} << 6) - ({6'd0, min_q} << 2) + {6'd0, sec_q};
  // Elapsed seconds times 100 = x*64 + x*32 + x*4
  assign diff_c   = total_q - left_q;
  assign diff_ext = {7'd0, diff_c};
  assign num_c    = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
  // One restoring-division step
  assign rem_ge  = rem_q >= {1'b0, dvs_q};
  assign rem_sub = rem_q - {1'b0, dvs_q};

  // Percent datapath registers
  always_ff @(posedge clk_i) begin
    if (prep_en) begin
      total_q <= total_c;
      left_q  <= left_c;
    end
    if (mul_en) begin
      pct_zero_q <= (total_q == '0) || (left_q > total_q) || done_q;
      rem_q      <= num_c;
      dvs_q      <= {total_q, 6'd0};
      quo_q      <= '0;
    end
    if (div_en) begin
      if (rem_ge) rem_q <= rem_sub;
      quo_q <= {quo_q[wbit_pkg::PctW-2:0], rem_ge};
      dvs_q <= dvs_q >> 1;
    end
  end

  // Control state, configuration and timer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wbit_pkg::ST_IDLE;
      cnt_q       <= '0;
      work_min_q  <= wbit_pkg::WorkMinRst;
      short_min_q <= wbit_pkg::ShortMinRst;
      long_min_q  <= wbit_pkg::LongMinRst;
      sess_tot_q  <= wbit_pkg::SessTotRst;
      min_q       <= wbit_pkg::WorkMinRst;
      sec_q       <= '0;
      sess_q      <= wbit_pkg::FirstSess;
      work_q      <= 1'b1;
      len_q       <= wbit_pkg::WorkMinRst;
      ended_q     <= 1'b0;
      warn_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      work_min_q  <= work_min_d;
      short_min_q <= short_min_d;
      long_min_q  <= long_min_d;
      sess_tot_q  <= sess_tot_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      sess_q      <= sess_d;
      work_q      <= work_d;
      len_q       <= len_d;
      ended_q     <= ended_d;
      warn_q      <= warn_d;
      done_q      <= done_d;
      if (mul_en) begin
        cnt_q <= wbit_pkg::DivSteps;
      end else if (div_en) begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (fin_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      out_min_q  <= min_q;
      out_sec_q  <= sec_q;
      out_sess_q <= sess_q;
      out_work_q <= work_q;
      out_pct_q  <= pct_zero_q ? '0 : quo_q;
      out_end_q  <= ended_q;
      out_warn_q <= warn_q;
      out_done_q <= done_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign minutes_left_o    = out_min_q;
  assign seconds_left_o    = out_sec_q;
  assign session_number_o  = out_sess_q;
  assign in_work_o         = out_work_q;
  assign percent_elapsed_o = out_pct_q;
  assign phase_end_o       = out_end_q;
  assign warning_o         = out_warn_q;
  assign all_done_o        = out_done_q;

`ifndef SYNTHESIS
  // Percent never exceeds a full phase
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_elapsed_o <= 7'd100)
    else $error("percent_elapsed out of range");

  // A finished cycle is reported as a phase end back in work, session one
  a_done_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_done_o) |->
      (phase_end_o && in_work_o && session_number_o == wbit_pkg::FirstSess
       && percent_elapsed_o == '0))
    else $error("all_done without reload");

  // Only one item in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while busy");

  // Seconds field stays a valid clock digit
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seconds_left_o <= wbit_pkg::LastSecond)
    else $error("seconds_left out of range");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the work/break interval timer core. A clocked
// driver feeds second ticks, restarts and register writes from a queue that
// the stimulus block fills; a clocked monitor predicts every readout from its
// own timer model and compares each result field against it. Sender gaps and
// receiver stalls change from segment to segment.
// ----------------------------------------------------------------------------
module tb_top;
  import wbit_pkg::*;

  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned QuietCycles   = 14;   // block latency plus margin
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned Segments      = 12;
  localparam int unsigned SegItems      = 75;
  localparam int unsigned RestartPct    = 2;
  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned PercentFull   = 100;
  localparam int unsigned LongEvery     = 4;
  localparam int unsigned FirstFreeIdx  = REG_SESS_TOT + 1;
  localparam int unsigned LastIdx       = 2**CfgIdxW - 1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  localparam int unsigned SendIdlePct [4] = '{0, 49, 0, 8};
  localparam int unsigned RecvStallPct[4] = '{0, 0, 49, 8};

  // One queued operation: a timer transaction or a register write
  typedef struct packed {
    logic                is_write;
    logic                restart;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    idle_mode_e          mode;
  } timer_op_t;

  typedef struct packed {
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [SessW-1:0] session;
    logic             in_work;
    logic [PctW-1:0]  percent;
    logic             phase_end;
    logic             warning;
    logic             all_done;
  } readout_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  // Block inputs, known from time zero
  logic                in_valid  = 1'b0;
  logic                restart   = 1'b0;
  logic                out_ready = 1'b1;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic             in_ready, out_valid, cfg_ready;
  logic [MinW-1:0]  minutes_left, seconds_left;
  logic [SessW-1:0] session_number;
  logic             in_work, phase_end, warning, all_done;
  logic [PctW-1:0]  percent_elapsed;

  // Bench bookkeeping
  timer_op_t   timer_ops[$];
  readout_t    predicted_readouts[$];
  logic        in_acc  = 1'b0;
  logic        cfg_acc = 1'b0;
  int unsigned quiet_cnt    = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_cnt      = 0;
  idle_mode_e  cur_mode     = IDLE_NONE;

  // Timer model: registers and countdown state
  logic [MinW-1:0]  work_min_r   = WorkMinRst;
  logic [MinW-1:0]  short_min_r  = ShortMinRst;
  logic [MinW-1:0]  long_min_r   = LongMinRst;
  logic [SessW-1:0] sess_total_r = SessTotRst;
  logic [MinW-1:0]  min_cnt      = WorkMinRst;
  logic [SecW-1:0]  sec_cnt      = '0;
  logic [SessW-1:0] sess_cnt     = FirstSess;
  logic             work_q       = 1'b1;
  logic [MinW-1:0]  phase_len    = WorkMinRst;

  work_break_interval_timer_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .restart_i        (restart),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .minutes_left_o   (minutes_left),
    .seconds_left_o   (seconds_left),
    .session_number_o (session_number),
    .in_work_o        (in_work),
    .percent_elapsed_o(percent_elapsed),
    .phase_end_o      (phase_end),
    .warning_o        (warning),
    .all_done_o       (all_done),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Back to work phase of session one at full length
  function automatic void reload_work();
    min_cnt   = work_min_r;
    sec_cnt   = '0;
    sess_cnt  = FirstSess;
    work_q    = 1'b1;
    phase_len = work_min_r;
  endfunction

  // Register write; listed registers also reload the timer
  function automatic void write_timer_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_WORK_MIN:  work_min_r   = data[MinW-1:0];
      REG_SHORT_MIN: short_min_r  = data[MinW-1:0];
      REG_LONG_MIN:  long_min_r   = data[MinW-1:0];
      REG_SESS_TOT:  sess_total_r = data[SessW-1:0];
      default:       return;
    endcase
    reload_work();
  endfunction

  // One tick or restart; returns the readout after the update
  function automatic readout_t advance_timer(logic do_restart);
    readout_t    r;
    int unsigned total, left;
    r = '0;
    if (do_restart) begin
      reload_work();
    end else if (sec_cnt == 0 && min_cnt != 0) begin
      sec_cnt = LastSecond;
      min_cnt = min_cnt - 1'b1;
    end else if (sec_cnt == 0) begin
      // phase expired
      r.phase_end = 1'b1;
      if (sess_cnt >= sess_total_r) begin
        reload_work();
        r.all_done = 1'b1;
      end else begin
        work_q = ~work_q;
        if (work_q) begin
          phase_len = work_min_r;
          sess_cnt  = sess_cnt + 1'b1;
        end else if (sess_cnt % LongEvery == 0) begin
          phase_len = long_min_r;
        end else begin
          phase_len = short_min_r;
        end
        min_cnt = phase_len;
      end
    end else begin
      if (sec_cnt == WarnSecond && min_cnt == 0) r.warning = 1'b1;
      sec_cnt = sec_cnt - 1'b1;
    end

    total = phase_len * SecsPerMin;
    left  = min_cnt * SecsPerMin + sec_cnt;
    if (r.all_done || total == 0 || left > total) r.percent = '0;
    else r.percent = PctW'((total - left) * PercentFull / total);
    r.minutes = min_cnt;
    r.seconds = sec_cnt;
    r.session = sess_cnt;
    r.in_work = work_q;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Driver: launches queued operations at the falling edge
  always @(negedge clk) begin : driver
    logic      hold_in, hold_cfg;
    timer_op_t op;
    hold_in  = in_valid && !in_acc;
    hold_cfg = cfg_valid && !cfg_acc;
    if (rst_n && !hold_in && !hold_cfg && timer_ops.size() != 0) begin
      op = timer_ops[0];
      if (op.is_write) begin
        // register writes only once the block has gone quiet
        if (predicted_readouts.size() == 0 && quiet_cnt >= QuietCycles) begin
          cfg_index <= op.idx;
          cfg_data  <= op.data;
          hold_cfg  = 1'b1;
          void'(timer_ops.pop_front());
        end
      end else begin
        cur_mode = op.mode;
        if ($urandom_range(99) >= SendIdlePct[cur_mode]) begin
          restart <= op.restart;
          hold_in = 1'b1;
          void'(timer_ops.pop_front());
        end
      end
    end
    in_valid  <= hold_in;
    cfg_valid <= hold_cfg;
    out_ready <= ($urandom_range(99) >= RecvStallPct[cur_mode]);
  end

  // Monitor: checks results, then predicts newly accepted transactions
  always @(posedge clk) begin : monitor
    readout_t want;
    in_acc  <= in_valid && in_ready;
    cfg_acc <= cfg_valid && cfg_ready;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_readouts.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %0d:%0d session %0d",
                 $time, minutes_left, seconds_left, session_number);
      end else begin
        want = predicted_readouts.pop_front();
        check_field("minutes_left",    want.minutes,   minutes_left);
        check_field("seconds_left",    want.seconds,   seconds_left);
        check_field("session_number",  want.session,   session_number);
        check_field("in_work",         want.in_work,   in_work);
        check_field("percent_elapsed", want.percent,   percent_elapsed);
        check_field("phase_end",       want.phase_end, phase_end);
        check_field("warning",         want.warning,   warning);
        check_field("all_done",        want.all_done,  all_done);
      end
    end
    if (rst_n && cfg_valid && cfg_ready) write_timer_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && in_ready) predicted_readouts.push_back(advance_timer(restart));
    if (predicted_readouts.size() == 0 && !in_valid && !out_valid) quiet_cnt <= quiet_cnt + 1;
    else quiet_cnt <= 0;
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_second(logic do_restart, idle_mode_e mode);
    timer_op_t op;
    op         = '0;
    op.restart = do_restart;
    op.mode    = mode;
    timer_ops.push_back(op);
  endtask

  task automatic push_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    timer_op_t op;
    op          = '0;
    op.is_write = 1'b1;
    op.idx      = idx;
    op.data     = data;
    timer_ops.push_back(op);
  endtask

  // Mostly tiny phase lengths so that expiries come often
  function automatic logic [CfgDataW-1:0] pick_minutes();
    if ($urandom_range(99) < 80) return CfgDataW'($urandom_range(2));
    return CfgDataW'($urandom_range(2**CfgDataW - 1));
  endfunction

  // Stimulus and end of run
  initial begin : stimulus
    idle_mode_e mode;
    // directed: reset values, restart, ticks
    push_second(1'b1, IDLE_NONE);
    push_second(1'b0, IDLE_NONE);
    push_second(1'b0, IDLE_NONE);
    // zero-length phases, two sessions, plus an ignored write
    push_write(REG_WORK_MIN, 7'd0);
    push_write(REG_SHORT_MIN, 7'd0);
    push_write(REG_LONG_MIN, 7'd0);
    push_write(REG_SESS_TOT, 7'd2);
    push_write(CfgIdxW'($urandom_range(LastIdx, FirstFreeIdx)), 7'h55);
    repeat (4) push_second(1'b0, IDLE_NONE);
    // session total zero: every expiry ends the cycle
    push_write(REG_SESS_TOT, 7'd0);
    repeat (2) push_second(1'b0, IDLE_NONE);
    // masked data, long break after session four
    push_write(REG_LONG_MIN, 7'h41);
    push_write(REG_SESS_TOT, 7'h45);
    repeat (9) push_second(1'b0, IDLE_NONE);
    push_second(1'b1, IDLE_NONE);
    push_second(1'b0, IDLE_NONE);

    // random segments, each with fresh settings and its own idle pattern
    for (int seg = 0; seg < Segments; seg++) begin
      mode = idle_mode_e'(seg % 4);
      if (seg == 0) begin
        push_write(REG_WORK_MIN, '1);
        push_write(REG_SHORT_MIN, '1);
        push_write(REG_LONG_MIN, '1);
        push_write(REG_SESS_TOT, '1);
      end else if (seg == 1) begin
        push_write(REG_WORK_MIN, '0);
        push_write(REG_SHORT_MIN, '0);
        push_write(REG_LONG_MIN, '0);
        push_write(REG_SESS_TOT, '0);
      end else begin
        push_write(REG_WORK_MIN, pick_minutes());
        push_write(REG_SHORT_MIN, pick_minutes());
        push_write(REG_LONG_MIN, pick_minutes());
        if ($urandom_range(99) < 80) push_write(REG_SESS_TOT, CfgDataW'($urandom_range(6)));
        else push_write(REG_SESS_TOT, CfgDataW'($urandom_range(2**CfgDataW - 1)));
      end
      if ($urandom_range(99) < 25)
        push_write(CfgIdxW'($urandom_range(LastIdx, FirstFreeIdx)), CfgDataW'($urandom));
      for (int n = 0; n < SegItems; n++)
        push_second($urandom_range(99) < RestartPct, mode);
    end

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (timer_ops.size() != 0 || in_valid || cfg_valid || predicted_readouts.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
